// ===== rtl/core/plss_pkg.sv =====
package plss_pkg;

	localparam int LFSR_W           = 18;
	localparam int CODE_W           = 18;
	localparam int JUMP_STEPS       = 18;
	localparam int HIGH_OFFSET_LOG2 = 17;

	typedef logic [LFSR_W-1:0] lfsr_t;
	typedef lfsr_t [LFSR_W-1:0] lfsr_mat_t;
	typedef lfsr_mat_t [JUMP_STEPS-1:0] lfsr_mat_set_t;
	typedef logic [1:0] rot_t;

	localparam lfsr_t X_SEED = 18'h00001;
	localparam lfsr_t Y_SEED = 18'h3ffff;

	localparam rot_t ROT_NONE      = 2'd0;
	localparam rot_t ROT_QUARTER_A = 2'd1;
	localparam rot_t ROT_HALF      = 2'd2;
	localparam rot_t ROT_QUARTER_B = 2'd3;

	localparam logic DIR_DESCRAMBLE = 1'b0;
	localparam logic DIR_SCRAMBLE   = 1'b1;

	typedef enum logic {
		REG_CODE_NUMBER = 1'b0,
		REG_DIRECTION   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		lfsr_t x_high;
		lfsr_t y_high;
		lfsr_t x_low;
		lfsr_t y_low;
	} lfsr_set_t;

	typedef struct packed {
		logic  valid;
		lfsr_t x_low;
		lfsr_t x_high;
	} seed_wr_t;

	// x(i+18) = x(i+7) ^ x(i)
	function automatic lfsr_t step_x(input lfsr_t s);
		return {s[0] ^ s[7], s[LFSR_W-1:1]};
	endfunction

	// y(i+18) = y(i+10) ^ y(i+7) ^ y(i+5) ^ y(i)
	function automatic lfsr_t step_y(input lfsr_t s);
		return {s[0] ^ s[5] ^ s[7] ^ s[10], s[LFSR_W-1:1]};
	endfunction

	// Column j of m is the image of basis vector j.
	function automatic lfsr_t mat_vec(input lfsr_mat_t m, input lfsr_t v);
		lfsr_t r;
		r = '0;
		for (int j = 0; j < LFSR_W; j++) begin
			if (v[j])
				r = r ^ m[j];
		end
		return r;
	endfunction

	// Entry k advances the register by 2**k steps.
	function automatic lfsr_mat_set_t build_pows(input logic use_y);
		lfsr_mat_set_t m;
		lfsr_t         e;
		m = '0;
		for (int j = 0; j < LFSR_W; j++) begin
			e = lfsr_t'(1) << j;
			m[0][j] = use_y ? step_y(e) : step_x(e);
		end
		for (int k = 1; k < JUMP_STEPS; k++) begin
			for (int j = 0; j < LFSR_W; j++)
				m[k][j] = mat_vec(m[k-1], m[k-1][j]);
		end
		return m;
	endfunction

	localparam lfsr_mat_set_t X_POW2 = build_pows(1'b0);
	localparam lfsr_mat_set_t Y_POW2 = build_pows(1'b1);

	localparam lfsr_t X_HIGH_RESET = mat_vec(X_POW2[HIGH_OFFSET_LOG2], X_SEED);
	localparam lfsr_t Y_HIGH_SEED  = mat_vec(Y_POW2[HIGH_OFFSET_LOG2], Y_SEED);

	localparam lfsr_set_t RESET_SET = '{
		x_high: X_HIGH_RESET,
		y_high: Y_HIGH_SEED,
		x_low:  X_SEED,
		y_low:  Y_SEED
	};

endpackage

// ===== rtl/core/plss_jump.sv =====
module plss_jump (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [plss_pkg::CODE_W-1:0]       code,
	output logic                              busy,
	output plss_pkg::seed_wr_t                seed_wr
);

	localparam int K_W   = $clog2(plss_pkg::JUMP_STEPS + 1);
	localparam int SEL_W = $clog2(plss_pkg::JUMP_STEPS);

	logic [K_W-1:0]               k_q;
	logic                         busy_q;
	logic [plss_pkg::CODE_W-1:0]  code_q;
	plss_pkg::lfsr_t              s_q;
	logic [SEL_W-1:0]             sel;
	plss_pkg::lfsr_t              prod;
	logic                         last;

	assign last = (k_q == K_W'(plss_pkg::JUMP_STEPS));

	// On the last pass the same product moves the low start to the high one.
	always_comb begin
		sel  = last ? SEL_W'(plss_pkg::HIGH_OFFSET_LOG2) : k_q[SEL_W-1:0];
		prod = plss_pkg::mat_vec(plss_pkg::X_POW2[sel], s_q);
	end

	assign busy           = busy_q;
	assign seed_wr.valid  = busy_q & last;
	assign seed_wr.x_low  = s_q;
	assign seed_wr.x_high = prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (busy_q) begin
			if (last)
				busy_q <= 1'b0;
			else
				k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			code_q <= code;
			s_q    <= plss_pkg::X_SEED;
		end else if (busy_q && !last && code_q[k_q[SEL_W-1:0]]) begin
			s_q <= prod;
		end
	end

endmodule

// ===== rtl/core/plss_seq.sv =====
module plss_seq #(
	parameter int HALF_LENGTH = 131072
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 frame_start,
	input  plss_pkg::seed_wr_t   seed_wr,
	output plss_pkg::rot_t       rotation
);

	localparam int POS_W = $clog2(HALF_LENGTH);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(HALF_LENGTH - 1);
	localparam logic ADDR_RUN  = 1'b0;
	localparam logic ADDR_SEED = 1'b1;

	typedef struct packed {
		logic [POS_W-1:0]    pos;
		plss_pkg::lfsr_set_t lfsr;
	} word_t;

	localparam word_t RESET_WORD = '{pos: '0, lfsr: plss_pkg::RESET_SET};

	word_t mem [2];
	word_t rd_run_q;
	word_t rd_seed_q;
	word_t fwd_q;
	logic  fwd_vld_q;
	logic  fwd_addr_q;
	logic  run_vld_q;
	logic  seed_vld_q;

	logic  wr_en;
	logic  wr_addr;
	word_t wr_data;
	word_t seed_new;
	word_t run_eff;
	word_t seed_eff;
	word_t cur;
	word_t stepped;
	word_t next_word;

	always_comb begin
		seed_new.pos         = '0;
		seed_new.lfsr.x_high = seed_wr.x_high;
		seed_new.lfsr.y_high = plss_pkg::Y_HIGH_SEED;
		seed_new.lfsr.x_low  = seed_wr.x_low;
		seed_new.lfsr.y_low  = plss_pkg::Y_SEED;

		// Last cycle's write is not yet in the read registers: forward it.
		if (fwd_vld_q && fwd_addr_q == ADDR_RUN)
			run_eff = fwd_q;
		else if (run_vld_q)
			run_eff = rd_run_q;
		else
			run_eff = RESET_WORD;

		if (fwd_vld_q && fwd_addr_q == ADDR_SEED)
			seed_eff = fwd_q;
		else if (seed_vld_q)
			seed_eff = rd_seed_q;
		else
			seed_eff = RESET_WORD;

		cur = frame_start ? seed_eff : run_eff;

		stepped.pos         = cur.pos + 1'b1;
		stepped.lfsr.x_high = plss_pkg::step_x(cur.lfsr.x_high);
		stepped.lfsr.y_high = plss_pkg::step_y(cur.lfsr.y_high);
		stepped.lfsr.x_low  = plss_pkg::step_x(cur.lfsr.x_low);
		stepped.lfsr.y_low  = plss_pkg::step_y(cur.lfsr.y_low);

		// Reload after the last position of a half period.
		next_word = (cur.pos == POS_LAST) ? seed_eff : stepped;

		wr_en   = seed_wr.valid | adv;
		wr_addr = seed_wr.valid ? ADDR_SEED : ADDR_RUN;
		wr_data = seed_wr.valid ? seed_new : next_word;
	end

	assign rotation = {cur.lfsr.x_high[0] ^ cur.lfsr.y_high[0],
	                   cur.lfsr.x_low[0] ^ cur.lfsr.y_low[0]};

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_run_q   <= mem[ADDR_RUN];
		rd_seed_q  <= mem[ADDR_SEED];
		fwd_q      <= wr_data;
		fwd_addr_q <= wr_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q  <= 1'b0;
			run_vld_q  <= 1'b0;
			seed_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= wr_en;
			if (wr_en && wr_addr == ADDR_RUN)
				run_vld_q <= 1'b1;
			if (wr_en && wr_addr == ADDR_SEED)
				seed_vld_q <= 1'b1;
		end
	end

endmodule

// ===== rtl/core/plss_rotate.sv =====
module plss_rotate #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic signed [SAMPLE_WIDTH-1:0] re,
	input  logic signed [SAMPLE_WIDTH-1:0] im,
	input  plss_pkg::rot_t                 rot,
	input  logic                           dir,
	output logic signed [SAMPLE_WIDTH-1:0] out_re,
	output logic signed [SAMPLE_WIDTH-1:0] out_im
);

	localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

	function automatic logic signed [SAMPLE_WIDTH-1:0] neg_sat(
		input logic signed [SAMPLE_WIDTH-1:0] v
	);
		return (v == S_MIN) ? S_MAX : -v;
	endfunction

	logic plus90;

	always_comb begin
		plus90 = ((rot == plss_pkg::ROT_QUARTER_A) == (dir == plss_pkg::DIR_SCRAMBLE));
		case (rot)
			plss_pkg::ROT_NONE: begin
				out_re = re;
				out_im = im;
			end
			plss_pkg::ROT_HALF: begin
				out_re = neg_sat(re);
				out_im = neg_sat(im);
			end
			default: begin
				if (plus90) begin
					out_re = neg_sat(im);
					out_im = re;
				end else begin
					out_re = im;
					out_im = neg_sat(re);
				end
			end
		endcase
	end

endmodule

// ===== rtl/core/plss_out_buf.sv =====
module plss_out_buf #(
	parameter int WIDTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             space,
	input  logic [WIDTH-1:0] push_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic             out_vld_q;
	logic             skid_vld_q;
	logic [WIDTH-1:0] out_q;
	logic [WIDTH-1:0] skid_q;
	logic             take;

	assign space     = !skid_vld_q;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;
	assign take      = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (take) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= push;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	// Hold the waiting beat and park a new one in the skid stage while stalled; on a move, the skid beat goes out first.
	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_vld_q ? skid_q : push_data;
			if (skid_vld_q && push)
				skid_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== rtl/core/pl_symbol_scrambler.sv =====
// Channel | Direction | tdata (low bit up)                       | tuser
// s_*     | in        | sample_re, sample_im, zero pad           | frame_start
// m_*     | out       | out_re, out_im, rotation, zero pad       | -
// cfg_*   | in        | cfg_index 0 code_number, 1 direction     | -
//
// One beat per clock in, one per clock out while m_tready is high and no jump-ahead
// runs; a result is registered in the output buffer before it reaches m_*. The
// sequence state sits in a two-entry memory (running LFSRs, reload seeds) read every
// cycle, with the last write forwarded. A code_number write starts a jump-ahead
// over its 18 bits, one per cycle, then derives the high seed; s_tready is low meanwhile.
// A two-beat output buffer lets input flow while m_tready is low for one beat.
// Reset leaves code 0 and descramble selected.
module pl_symbol_scrambler #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int HALF_LENGTH  = 131072,
	localparam int S_TDATA_W   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int M_TDATA_W   = ((2 * SAMPLE_WIDTH + 2 + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [S_TDATA_W-1:0]         s_tdata,   // sample_re, sample_im
	input  logic                         s_tuser,   // frame_start

	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [M_TDATA_W-1:0]         m_tdata,   // out_re, out_im, rotation

	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [plss_pkg::CODE_W-1:0]  cfg_data
);

	localparam int RES_W = 2 * SAMPLE_WIDTH + 2;

	logic                           dir_q;
	logic                           accept;
	logic                           space;
	logic                           jump_busy;
	logic                           code_we;
	plss_pkg::seed_wr_t             seed_wr;
	plss_pkg::rot_t                 rotation;
	logic signed [SAMPLE_WIDTH-1:0] sample_re;
	logic signed [SAMPLE_WIDTH-1:0] sample_im;
	logic signed [SAMPLE_WIDTH-1:0] out_re;
	logic signed [SAMPLE_WIDTH-1:0] out_im;
	logic [M_TDATA_W-1:0]           result;

	assign sample_re = s_tdata[SAMPLE_WIDTH-1:0];
	assign sample_im = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
	assign s_tready  = space & !jump_busy;
	assign accept    = s_tvalid & s_tready;
	assign code_we   = cfg_we && (plss_pkg::reg_idx_t'(cfg_index) == plss_pkg::REG_CODE_NUMBER);
	assign result    = M_TDATA_W'({rotation, out_im, out_re});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= plss_pkg::DIR_DESCRAMBLE;
		end else if (cfg_we) begin
			unique case (plss_pkg::reg_idx_t'(cfg_index))
				plss_pkg::REG_DIRECTION:   dir_q <= cfg_data[0];
				plss_pkg::REG_CODE_NUMBER: dir_q <= dir_q;
				default:                   dir_q <= dir_q;
			endcase
		end
	end

	plss_jump u_jump (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (code_we),
		.code    (cfg_data),
		.busy    (jump_busy),
		.seed_wr (seed_wr)
	);

	plss_seq #(
		.HALF_LENGTH (HALF_LENGTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (accept),
		.frame_start (s_tuser),
		.seed_wr     (seed_wr),
		.rotation    (rotation)
	);

	plss_rotate #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_rotate (
		.re     (sample_re),
		.im     (sample_im),
		.rot    (rotation),
		.dir    (dir_q),
		.out_re (out_re),
		.out_im (out_im)
	);

	plss_out_buf #(
		.WIDTH (M_TDATA_W)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.space     (space),
		.push_data (result),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	if (RES_W > M_TDATA_W) begin : g_width_bad
		$error("result does not fit m_tdata");
	end

endmodule

// ===== rtl/core/plss_checker.sv =====
module plss_checker #(
	parameter int M_TDATA_W = 40
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [M_TDATA_W-1:0]         m_tdata,
	input logic                         cfg_we,
	input logic                         cfg_index
);

	logic [1:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = s_tvalid & s_tready;
	assign out_beat = m_tvalid & m_tready;

	// Beats taken in whose results are not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (in_beat && !out_beat)
			pend_q <= pend_q + 1'b1;
		else if (out_beat && !in_beat)
			pend_q <= pend_q - 1'b1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("output beat without a pending input");

	a_buf_full: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> !s_tready)
		else $error("input taken with both output stages full");

	a_jump_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == plss_pkg::REG_CODE_NUMBER |=> !s_tready)
		else $error("input taken while seeds are recomputed");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("pending beat count overflow");

endmodule

bind pl_symbol_scrambler plss_checker #(
	.M_TDATA_W (M_TDATA_W)
) u_plss_checker (.*);

// ===== sim/pl_symbol_scrambler_tb.sv =====
`timescale 1ns / 100ps

module pl_symbol_scrambler_tb;

	localparam int HALF_LEN    = 131072;
	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [15:0] re;
		logic [15:0] im;
		logic        fs;
	} sym_in_t;

	typedef struct {
		logic [15:0]    re;
		logic [15:0]    im;
		plss_pkg::rot_t rot;
	} sym_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // sample_re, sample_im
	logic        s_tuser = 1'b0; // frame_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // out_re, out_im, rotation, zero pad
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [plss_pkg::CODE_W-1:0] cfg_data = '0;

	sym_in_t  pending_syms[$];
	sym_out_t predicted_syms[$];
	int       mismatches = 0;
	int       idle_cycles = 0;
	int       src_gap = 0;
	int       sink_gap = 0;
	int       hold_left = 0;
	bit       hold_arm = 1'b0;
	bit       hold_done = 1'b0;
	bit       allow_gaps = 1'b1;
	bit       in_taken = 1'b0;

	// scrambling sequence state
	plss_pkg::lfsr_t x_lo, y_lo, x_hi, y_hi;
	plss_pkg::lfsr_t x_seed_lo, x_seed_hi, y_seed_hi;
	int    seq_pos;
	logic  dir_reg;

	logic [15:0] extreme_vals[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};

	pl_symbol_scrambler #(
		.SAMPLE_WIDTH(16),
		.HALF_LENGTH(HALF_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic plss_pkg::lfsr_t x_next(input plss_pkg::lfsr_t s);
		return {s[7] ^ s[0], s[17:1]};
	endfunction

	function automatic plss_pkg::lfsr_t y_next(input plss_pkg::lfsr_t s);
		return {s[10] ^ s[7] ^ s[5] ^ s[0], s[17:1]};
	endfunction

	function automatic logic [15:0] neg_clip(input logic [15:0] v);
		return (v == 16'h8000) ? 16'h7fff : (~v + 16'd1);
	endfunction

	function automatic logic [15:0] pick_sample();
		if ($urandom_range(0, 5) == 0)
			return extreme_vals[$urandom_range(0, 3)];
		return 16'($urandom);
	endfunction

	// x seeds for code n: n steps from the x seed, then half a period further
	task automatic load_code(input logic [plss_pkg::CODE_W-1:0] n);
		plss_pkg::lfsr_t s;
		s = plss_pkg::X_SEED;
		for (int i = 0; i < int'(n); i++)
			s = x_next(s);
		x_seed_lo = s;
		for (int i = 0; i < HALF_LEN; i++)
			s = x_next(s);
		x_seed_hi = s;
	endtask

	task automatic reload_sequence();
		x_lo = x_seed_lo;
		x_hi = x_seed_hi;
		y_lo = plss_pkg::Y_SEED;
		y_hi = y_seed_hi;
		seq_pos = 0;
	endtask

	task automatic rotate_symbol(input logic [15:0] re, input logic [15:0] im, input logic fs);
		sym_out_t r;
		if (fs)
			reload_sequence();
		r.rot = {x_hi[0] ^ y_hi[0], x_lo[0] ^ y_lo[0]};
		x_lo = x_next(x_lo);
		x_hi = x_next(x_hi);
		y_lo = y_next(y_lo);
		y_hi = y_next(y_hi);
		seq_pos++;
		if (seq_pos >= HALF_LEN)
			reload_sequence();
		case (r.rot)
			plss_pkg::ROT_NONE: begin
				r.re = re;
				r.im = im;
			end
			plss_pkg::ROT_HALF: begin
				r.re = neg_clip(re);
				r.im = neg_clip(im);
			end
			default: begin
				// +90 degrees is (-im, re), -90 degrees is (im, -re)
				if ((r.rot == plss_pkg::ROT_QUARTER_A) ==
						(dir_reg == plss_pkg::DIR_SCRAMBLE)) begin
					r.re = neg_clip(im);
					r.im = re;
				end else begin
					r.re = im;
					r.im = neg_clip(re);
				end
			end
		endcase
		predicted_syms.push_back(r);
	endtask

	task automatic write_reg(input plss_pkg::reg_idx_t idx,
			input logic [plss_pkg::CODE_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == plss_pkg::REG_CODE_NUMBER)
			load_code(val);
		else
			dir_reg = val[0];
	endtask

	task automatic wait_drained();
		while (pending_syms.size() != 0 || s_tvalid || predicted_syms.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic run_phase(input logic dir, input logic [plss_pkg::CODE_W-1:0] code,
			input int count, input bit gaps, input int fs_odds, input bit restart);
		bit fs;
		wait_drained();
		write_reg(plss_pkg::REG_DIRECTION, {17'd0, dir});
		write_reg(plss_pkg::REG_CODE_NUMBER, code);
		allow_gaps = gaps;
		for (int k = 0; k < count; k++) begin
			fs = (k == 0) ? restart : (fs_odds > 0 && $urandom_range(0, fs_odds - 1) == 0);
			pending_syms.push_back('{re: pick_sample(), im: pick_sample(), fs: fs});
		end
	endtask

	// source: present the next beat once the current one is taken
	always @(negedge clk) begin : src_drive
		sym_in_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_syms.size() > 0) begin
				nxt = pending_syms.pop_front();
				s_tdata <= {nxt.im, nxt.re};
				s_tuser <= nxt.fs;
				s_tvalid <= 1'b1;
				if (allow_gaps && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 8);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink: random back-pressure plus one long hold-off
	always @(negedge clk) begin : sink_drive
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_arm && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (allow_gaps && $urandom_range(0, 6) == 0)
				sink_gap = $urandom_range(1, 8);
		end
	end

	always @(posedge clk) begin : sym_check
		sym_out_t want;
		logic [15:0] got_re, got_im;
		plss_pkg::rot_t got_rot;
		in_taken = arst_n && s_tvalid && s_tready;
		if (in_taken)
			rotate_symbol(s_tdata[15:0], s_tdata[31:16], s_tuser);
		if (arst_n && m_tvalid && m_tready) begin
			got_re = m_tdata[15:0];
			got_im = m_tdata[31:16];
			got_rot = m_tdata[33:32];
			if (predicted_syms.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat re=%0d im=%0d rot=%0d",
						$signed(got_re), $signed(got_im), got_rot);
			end else begin
				want = predicted_syms.pop_front();
				if (got_re !== want.re || got_im !== want.im || got_rot !== want.rot) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected re=%0d im=%0d rot=%0d, got re=%0d im=%0d rot=%0d",
							$signed(want.re), $signed(want.im), want.rot,
							$signed(got_re), $signed(got_im), got_rot);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("pl_symbol_scrambler test failed");
				$finish;
			end
		end
	end

	initial begin
		plss_pkg::lfsr_t s;
		s = plss_pkg::Y_SEED;
		for (int i = 0; i < HALF_LEN; i++)
			s = y_next(s);
		y_seed_hi = s;
		dir_reg = plss_pkg::DIR_DESCRAMBLE;
		load_code('0);
		reload_sequence();

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: every extreme pair, first beat without a frame start
		for (int k = 0; k < 16; k++)
			pending_syms.push_back('{re: extreme_vals[k % 4], im: extreme_vals[k / 4],
				fs: (k == 8)});

		run_phase(plss_pkg::DIR_SCRAMBLE, 18'd0, 200, 1'b1, 48, 1'b1);
		// code change mid-frame: keep the old sequence until the next reload
		run_phase(plss_pkg::DIR_DESCRAMBLE, 18'd262142, 200, 1'b1, 48, 1'b0);
		hold_arm = 1'b1;
		run_phase(plss_pkg::DIR_SCRAMBLE, 18'h3ffff, 200, 1'b1, 48, 1'b1);
		run_phase(plss_pkg::DIR_DESCRAMBLE, 18'd1, 200, 1'b0, 32, 1'b1);
		run_phase(1'($urandom), 18'($urandom_range(0, 262143)), 250, 1'b1, 40,
			1'($urandom));
		// closing stretch runs at full rate on both sides
		run_phase(plss_pkg::DIR_SCRAMBLE, 18'($urandom_range(0, 262143)), 250, 1'b0, 24,
			1'b1);

		wait_drained();
		if (mismatches == 0 && predicted_syms.size() == 0)
			$display("pl_symbol_scrambler test passed");
		else
			$display("pl_symbol_scrambler test failed");
		$finish;
	end

endmodule
